>>> sv/swq_pkg.sv
// Shared types and sizing constants for the sleep queue with timer wakeup.
`default_nettype none
package swq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [7:0]  thread_id;
    logic [19:0] delay;
    logic        cpu_idle;
  } in_t;

  typedef struct packed {
    logic       woken_valid;
    logic [7:0] woken_id;
    logic       accepted;
    logic       queue_full;
    logic       yield_on_return;
    logic       last;
  } out_t;

  // Classified request: wake time for a sleep, current time for a tick.
  typedef struct packed {
    logic        is_tick;
    logic [31:0] time_val;
    logic [7:0]  thread_id;
    logic        cpu_idle;
  } req_t;

  // Request queue toward the back part.
  typedef struct packed {
    logic valid;
    req_t req;
  } req_link_t;

endpackage
`default_nettype wire

>>> sv/sleep_queue_wakeup_top.sv
// Path: an accepted sleep request is registered in the front queue, and its result
//   then in the result queue, from which it can be popped.
// Throughput: one sleep request per cycle while the result queue has room; a tick
//   holds the back part to take it, scan one entry per cycle, check the end, close.
// A tick waking N threads needs N result slots; a full result queue stalls it.
// Reset: synchronous, active low; empties both queues and the table count.
// Table contents are not cleared, since only entries below the count are read.
`default_nettype none
module sleep_queue_wakeup_top
  import swq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  // request side
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  // result side
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  req_link_t link;
  logic      link_pop;
  logic      res_push;
  out_t      res;
  logic      res_full;

  // Front: classify each request (saturated wake time for sleeps) and queue it.
  swq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .link     (link),
    .link_pop (link_pop)
  );

  // Back: append sleeps, scan and compact the table on ticks.
  swq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .link     (link),
    .link_pop (link_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Results wait here so the back part keeps working while the consumer stalls.
  swq_out_fifo u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> sv/swq_front.sv
// Front part: classifies input requests and queues them for the back part.
`default_nettype none
module swq_front
  import swq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_t       in_data,
  output req_link_t      link,
  input  wire logic      link_pop
);

  localparam int QD = 2;

  req_t       mem [QD];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [32:0] sum;
  req_t       req_in;
  logic       do_push, do_pop;

  // Saturate the wake time at the top of the counter range.
  assign sum = {1'b0, in_data.now} + {13'b0, in_data.delay};

  always_comb begin
    req_in.is_tick   = (in_data.kind == KIND_TICK);
    req_in.thread_id = in_data.thread_id;
    req_in.cpu_idle  = in_data.cpu_idle;
    if (in_data.kind == KIND_TICK) begin
      req_in.time_val = in_data.now;
    end else begin
      req_in.time_val = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  assign full       = (cnt_r == 2'(QD));
  assign do_push    = push && !full;
  assign do_pop     = link_pop && (cnt_r != 2'd0);
  assign link.valid = (cnt_r != 2'd0);
  assign link.req   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/swq_back.sv
// Back: sleep table, append, one-entry-per-cycle scan; res_full can stall it.
`default_nettype none
module swq_back
  import swq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire req_link_t link,
  output logic           link_pop,
  output logic           res_push,
  output out_t           res,
  input  wire logic      res_full
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       entry_id_r   [QUEUE_DEPTH];
  logic [31:0]      entry_wake_r [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] keep_r, keep_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  logic [7:0]       hold_id_r, hold_id_nxt;
  logic [31:0]      now_r, now_nxt;
  logic             yld_r, yld_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_id;
  logic [31:0]      wr_wake;
  logic [7:0]       rd_id;
  logic [31:0]      rd_wake;

  assign rd_id   = entry_id_r[idx_r[IDX_W-1:0]];
  assign rd_wake = entry_wake_r[idx_r[IDX_W-1:0]];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    hold_valid_nxt = hold_valid_r;
    hold_id_nxt    = hold_id_r;
    now_nxt        = now_r;
    yld_nxt        = yld_r;
    link_pop       = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_id          = '0;
    wr_wake        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (link.valid && !res_full) begin
          link_pop = 1'b1;
          if (!link.req.is_tick) begin
            res_push = 1'b1;
            res.last = 1'b1;
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              res.queue_full = 1'b1;
            end else begin
              res.accepted = 1'b1;
              wr_en        = 1'b1;
              wr_addr      = count_r[IDX_W-1:0];
              wr_id        = link.req.thread_id;
              wr_wake      = link.req.time_val;
              count_nxt    = count_r + 1'b1;
            end
          end else begin
            now_nxt        = link.req.time_val;
            yld_nxt        = !link.req.cpu_idle;
            idx_nxt        = '0;
            keep_nxt       = '0;
            hold_valid_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = S_DONE;
        end else if (rd_wake <= now_r) begin
          // Hold the newest expired id; release the previous one as non-last.
          if (!(hold_valid_r && res_full)) begin
            if (hold_valid_r) begin
              res_push        = 1'b1;
              res.woken_valid = 1'b1;
              res.woken_id    = hold_id_r;
            end
            hold_valid_nxt = 1'b1;
            hold_id_nxt    = rd_id;
            idx_nxt        = idx_r + 1'b1;
          end
        end else begin
          // Compact the survivor down to the keep slot.
          wr_en    = 1'b1;
          wr_addr  = keep_r[IDX_W-1:0];
          wr_id    = rd_id;
          wr_wake  = rd_wake;
          keep_nxt = keep_r + 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res.woken_valid     = hold_valid_r;
          res.woken_id        = hold_valid_r ? hold_id_r : 8'd0;
          res.yield_on_return = yld_r;
          res.last            = 1'b1;
          count_nxt           = keep_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_id_r[wr_addr]   <= wr_id;
      entry_wake_r[wr_addr] <= wr_wake;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    yld_r     <= yld_nxt;
    hold_id_r <= hold_id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      keep_r       <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      keep_r       <= keep_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/swq_out_fifo.sv
// Two-entry result queue between the back part and the result ports.
`default_nettype none
module swq_out_fifo
  import swq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_push,
  input  wire out_t res,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  localparam int QD = 2;

  out_t       mem [QD];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign res_full = (cnt_r == 2'(QD));
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign out_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/sleep_queue_wakeup_chk.sv
// Port-level checker for the sleep queue, bound to the top level.
`default_nettype none
module sleep_queue_wakeup_chk
  import swq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic push,
  input wire logic full,
  input wire in_t  in_data,
  input wire logic empty,
  input wire logic pop,
  input wire out_t out_data
);

  // Reset drains both queues.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not drained after reset");

  // A refused request is held until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> (push && $stable(in_data)))
    else $error("waiting request changed");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

  // Only one kind of answer per result.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ($countones({out_data.woken_valid, out_data.accepted,
                            out_data.queue_full}) <= 1))
    else $error("result mixes sleep and wake answers");

  // Yield is carried only by the closing result of a tick.
  a_yield_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.yield_on_return) |->
      (out_data.last && !out_data.accepted && !out_data.queue_full))
    else $error("yield on a result that does not close a tick");

endmodule

bind sleep_queue_wakeup_top sleep_queue_wakeup_chk u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .in_data  (in_data),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
`default_nettype wire
